>>> sv/stb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stb_pkg;

    localparam int TIMER_SLOTS = 16;
    localparam int SLOT_W      = $clog2(TIMER_SLOTS);
    localparam int CNT_W       = $clog2(TIMER_SLOTS + 1);

    localparam logic [2:0] MODE_TICK   = 3'd0;
    localparam logic [2:0] MODE_CREATE = 3'd1;
    localparam logic [2:0] MODE_START  = 3'd2;
    localparam logic [2:0] MODE_STOP   = 3'd3;
    localparam logic [2:0] MODE_CHPER  = 3'd4;
    localparam logic [2:0] MODE_QUERY  = 3'd5;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [CNT_W-1:0]  t_count;

endpackage

`default_nettype wire

>>> sv/software_timer_bank_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Bank of software timers driven by tick and command items. An item is taken when start is
// high and busy is low. Create and query items finish straight from idle. Start, stop and
// change period items walk the active list to take the timer out, and start and change
// period then put it back at the end. A tick walks the list entry by entry in start order
// with a single adder and comparator. Results come from an output register and are shown for
// exactly one cycle under o_valid. A firing is held until the next firing is found or the
// walk ends, so that the final result can carry o_last. The receiver cannot stall, so the
// results of one tick may arrive in consecutive cycles and must all be taken. The last
// result of every item carries o_last.
module software_timer_bank_unit
    import stb_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [2:0]  i_mode,
    input  wire  [3:0]  i_timer_id,
    input  wire         i_repeat_flag,
    input  wire  [31:0] i_period_ticks,
    output logic        o_valid,
    output logic        o_fired,
    output logic [3:0]  o_fired_id,
    output logic        o_last,
    output logic [31:0] o_now_ticks,
    output logic        o_slot_is_active
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_REMOVE = 2'd1;
    localparam logic [1:0] S_TICK   = 2'd2;

    logic [1:0]       r_state;
    logic [2:0]       r_mode;
    t_slot            r_id;
    logic [31:0]      r_tick;
    logic             r_rep [TIMER_SLOTS];
    logic [31:0]      r_per [TIMER_SLOTS];
    logic [31:0]      r_exp [TIMER_SLOTS];
    logic [TIMER_SLOTS-1:0] r_act;
    t_slot            r_list [TIMER_SLOTS];
    t_count           r_count;
    t_count           r_i;
    t_count           r_w;
    logic             r_pend;
    logic [3:0]       r_pend_id;
    logic             r_pend_act;
    logic             r_out_valid;
    logic             r_out_fired;
    logic [3:0]       r_out_id;
    logic             r_out_last;
    logic             r_out_act;

    logic [31:0] id_ext;
    logic        id_ok;
    t_slot       id_slot;
    t_slot       walk_slot;
    logic [31:0] walk_ext;
    logic [31:0] operand;
    logic [31:0] sum;
    logic        fire;
    logic        walk_end;
    logic        room;

    assign id_ext    = 32'(i_timer_id);
    assign id_ok     = id_ext < 32'(TIMER_SLOTS);
    assign id_slot   = id_ext[SLOT_W-1:0];
    assign walk_slot = r_list[r_i[SLOT_W-1:0]];
    assign walk_ext  = 32'(walk_slot);
    assign walk_end  = r_i == r_count;
    assign room      = r_w < t_count'(TIMER_SLOTS);

    // One adder serves both the re-arm of a firing timer and a start or change of period.
    assign operand = (r_state == S_TICK) ? r_per[walk_slot] : r_per[r_id];
    assign sum     = r_tick + operand;
    assign fire    = r_exp[walk_slot] < r_tick;

    assign busy             = r_state != S_IDLE;
    assign o_valid          = r_out_valid;
    assign o_fired          = r_out_fired;
    assign o_fired_id       = r_out_id;
    assign o_last           = r_out_last;
    assign o_now_ticks      = r_tick;
    assign o_slot_is_active = r_out_act;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_QUERY;
            r_id        <= '0;
            r_tick      <= '0;
            r_act       <= '0;
            r_count     <= '0;
            r_i         <= '0;
            r_w         <= '0;
            r_pend      <= 1'b0;
            r_pend_id   <= '0;
            r_pend_act  <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_fired <= 1'b0;
            r_out_id    <= '0;
            r_out_last  <= 1'b0;
            r_out_act   <= 1'b0;
            for (int k = 0; k < TIMER_SLOTS; k++) begin
                r_rep[k] <= 1'b0;
                r_per[k] <= '0;
                r_exp[k] <= '0;
            end
        end else begin
            r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_mode <= i_mode;
                        r_id   <= id_slot;
                        r_i    <= '0;
                        r_w    <= '0;
                        r_pend <= 1'b0;
                        if (i_mode == MODE_TICK) begin
                            r_tick  <= r_tick + 32'd1;
                            r_state <= S_TICK;
                        end else if (id_ok && (i_mode == MODE_START || i_mode == MODE_STOP
                                               || i_mode == MODE_CHPER)) begin
                            r_act[id_slot] <= 1'b0;
                            if (i_mode == MODE_CHPER) begin
                                r_per[id_slot] <= i_period_ticks;
                            end
                            r_state <= S_REMOVE;
                        end else begin
                            if (id_ok && i_mode == MODE_CREATE) begin
                                r_rep[id_slot] <= i_repeat_flag;
                                r_per[id_slot] <= i_period_ticks;
                            end
                            r_out_valid <= 1'b1;
                            r_out_fired <= 1'b0;
                            r_out_id    <= '0;
                            r_out_last  <= 1'b1;
                            r_out_act   <= id_ok ? r_act[id_slot] : 1'b0;
                        end
                    end
                end
                S_REMOVE: begin
                    if (walk_end) begin
                        if (r_mode != MODE_STOP) begin
                            r_exp[r_id] <= sum;
                            r_act[r_id] <= 1'b1;
                            r_count     <= room ? r_w + t_count'(1) : r_w;
                        end else begin
                            r_count <= r_w;
                        end
                        r_out_valid <= 1'b1;
                        r_out_fired <= 1'b0;
                        r_out_id    <= '0;
                        r_out_last  <= 1'b1;
                        r_out_act   <= r_mode != MODE_STOP;
                        r_state     <= S_IDLE;
                    end else begin
                        if (walk_slot != r_id) begin
                            r_w <= r_w + t_count'(1);
                        end
                        r_i <= r_i + t_count'(1);
                    end
                end
                S_TICK: begin
                    if (walk_end) begin
                        r_count     <= r_w;
                        r_out_valid <= 1'b1;
                        r_out_fired <= r_pend;
                        r_out_id    <= r_pend ? r_pend_id : 4'd0;
                        r_out_last  <= 1'b1;
                        r_out_act   <= r_pend ? r_pend_act : 1'b0;
                        r_state     <= S_IDLE;
                    end else begin
                        r_i <= r_i + t_count'(1);
                        if (fire) begin
                            if (r_rep[walk_slot]) begin
                                r_exp[walk_slot] <= sum;
                                r_w              <= r_w + t_count'(1);
                            end else begin
                                r_act[walk_slot] <= 1'b0;
                            end
                            // A firing waits for the next one so the final one can carry last.
                            if (r_pend) begin
                                r_out_valid <= 1'b1;
                                r_out_fired <= 1'b1;
                                r_out_id    <= r_pend_id;
                                r_out_last  <= 1'b0;
                                r_out_act   <= r_pend_act;
                            end
                            r_pend     <= 1'b1;
                            r_pend_id  <= walk_ext[3:0];
                            r_pend_act <= r_rep[walk_slot];
                        end else begin
                            r_w <= r_w + t_count'(1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // The active list is compacted in place: entries are read at r_i and kept at r_w.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_REMOVE: begin
                if (walk_end) begin
                    if (r_mode != MODE_STOP && room) begin
                        r_list[r_w[SLOT_W-1:0]] <= r_id;
                    end
                end else if (walk_slot != r_id) begin
                    r_list[r_w[SLOT_W-1:0]] <= walk_slot;
                end
            end
            S_TICK: begin
                if (!walk_end && (!fire || r_rep[walk_slot])) begin
                    r_list[r_w[SLOT_W-1:0]] <= walk_slot;
                end
            end
            default: begin
            end
        endcase
    end

    a_nofire_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_fired |-> o_last)
        else $error("non-firing result without last");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_count'(TIMER_SLOTS))
        else $error("active list count out of range");

    a_list_matches_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> $countones(r_act) == int'(r_count))
        else $error("active flags disagree with list length");

    a_tick_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_mode == MODE_TICK |=> r_tick == $past(r_tick) + 32'd1)
        else $error("tick count did not advance");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> r_w <= r_i && r_i <= r_count)
        else $error("list walk indexes out of order");

endmodule

`default_nettype wire
